/* rtl/bvp_pkg.sv */
// Shared types, constants and saturating arithmetic helpers for the velocity pusher.
package bvp_pkg;

	// Field formats
	localparam int VEL_WIDTH  = 32;
	localparam int FLD_W      = 32;
	localparam int COEF_W     = 32;
	localparam int FRAC_SHIFT = 24;
	localparam int CFG_IDX_W  = 3;

	// Datapath and product widths
	localparam int DP_W   = VEL_WIDTH;
	localparam int PROD_W = DP_W + COEF_W;
	localparam int MAG_W  = PROD_W + 1 - FRAC_SHIFT;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KICK_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KICK_Y = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_KICK_Z = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_ROT_T  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_ROT_S  = CFG_IDX_W'(4);

	// Mode codes
	localparam logic MODE_VECTOR = 1'b0;
	localparam logic MODE_SHEAR  = 1'b1;

	typedef logic signed [FLD_W-1:0]  fld_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [DP_W-1:0]   dp_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

	typedef struct packed {
		dp_t  val;
		logic ovf;
	} sat_res_t;

	typedef struct packed {
		fld_t val;
		logic ovf;
	} fld_res_t;

	localparam dp_t DP_MAX = {1'b0, {(DP_W-1){1'b1}}};
	localparam dp_t DP_MIN = {1'b1, {(DP_W-1){1'b0}}};

	localparam logic [PROD_W:0]  RND_HALF    = (PROD_W+1)'(1) << (FRAC_SHIFT-1);
	localparam logic [MAG_W-1:0] MAG_NEG_LIM = MAG_W'(1) << (DP_W-1);
	localparam logic [MAG_W-1:0] MAG_POS_LIM = MAG_NEG_LIM - MAG_W'(1);

	localparam logic signed [63:0] FLD_MAX = 64'sd2147483647;
	localparam logic signed [63:0] FLD_MIN = -64'sd2147483648;

	// Saturating add or subtract on the datapath width
	function automatic sat_res_t sat_sum(dp_t a, dp_t b, logic do_sub);
		logic [DP_W:0] s;
		sat_res_t      r;
		if (do_sub) begin
			s = {a[DP_W-1], a} - {b[DP_W-1], b};
		end else begin
			s = {a[DP_W-1], a} + {b[DP_W-1], b};
		end
		r.ovf = s[DP_W] ^ s[DP_W-1];
		if (r.ovf) begin
			r.val = s[DP_W] ? DP_MIN : DP_MAX;
		end else begin
			r.val = dp_t'(s[DP_W-1:0]);
		end
		return r;
	endfunction

	// Round a product magnitude to nearest (halves away from zero), apply sign, saturate
	function automatic sat_res_t round_sat(logic [PROD_W-1:0] prod, logic neg);
		logic [PROD_W:0]  rnd;
		logic [MAG_W-1:0] mag;
		sat_res_t         r;
		rnd = {1'b0, prod} + RND_HALF;
		mag = rnd[PROD_W:FRAC_SHIFT];
		if (neg) begin
			r.ovf = mag > MAG_NEG_LIM;
			r.val = r.ovf ? DP_MIN : dp_t'(-mag[DP_W-1:0]);
		end else begin
			r.ovf = mag > MAG_POS_LIM;
			r.val = r.ovf ? DP_MAX : dp_t'(mag[DP_W-1:0]);
		end
		return r;
	endfunction

	// Clip a datapath value to the 32-bit result field
	function automatic fld_res_t clip_fld(dp_t x);
		logic signed [63:0] w;
		fld_res_t           r;
		w = 64'(x);
		if (w > FLD_MAX) begin
			r.ovf = 1'b1;
			r.val = fld_t'(FLD_MAX[FLD_W-1:0]);
		end else if (w < FLD_MIN) begin
			r.ovf = 1'b1;
			r.val = fld_t'(FLD_MIN[FLD_W-1:0]);
		end else begin
			r.ovf = 1'b0;
			r.val = fld_t'(w[FLD_W-1:0]);
		end
		return r;
	endfunction

endpackage

/* rtl/bvp_if.sv */
// Handshake channel interfaces: particle input, pushed result, and configuration writes.
interface bvp_in_if;
	import bvp_pkg::*;
	logic valid;
	logic ready;
	logic mode;
	fld_t vel_x;
	fld_t vel_y;
	fld_t vel_z;
	fld_t dphi_x;
	fld_t dphi_y;
	fld_t dphi_z;
	modport source (output valid, mode, vel_x, vel_y, vel_z, dphi_x, dphi_y, dphi_z,
		input ready);
	modport sink (input valid, mode, vel_x, vel_y, vel_z, dphi_x, dphi_y, dphi_z,
		output ready);
endinterface

interface bvp_out_if;
	import bvp_pkg::*;
	logic valid;
	logic ready;
	fld_t new_vx;
	fld_t new_vy;
	fld_t new_vz;
	logic saturated;
	modport source (output valid, new_vx, new_vy, new_vz, saturated, input ready);
	modport sink (input valid, new_vx, new_vy, new_vz, saturated, output ready);
endinterface

interface bvp_cfg_if;
	import bvp_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	fld_t     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/bvp_mulq.sv */
// Q8.24 scaling multiplier: registered sign-magnitude product, then round and saturate.
module bvp_mulq (
	input  logic            clk,
	input  logic            en,
	input  bvp_pkg::dp_t    a,
	input  bvp_pkg::coef_t  b,
	output bvp_pkg::sat_res_t res
);
	import bvp_pkg::*;

	logic [DP_W-1:0]   a_mag;
	logic [COEF_W-1:0] b_mag;
	logic [PROD_W-1:0] prod_q;
	logic              neg_q;

	assign a_mag = a[DP_W-1]   ? unsigned'(dp_t'(-a))   : unsigned'(a);
	assign b_mag = b[COEF_W-1] ? unsigned'(coef_t'(-b)) : unsigned'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a_mag) * PROD_W'(b_mag);
			neg_q  <= a[DP_W-1] ^ b[COEF_W-1];
		end
	end

	assign res = round_sat(prod_q, neg_q);

endmodule

/* rtl/boris_velocity_push.sv */
// Boris velocity push: a nine-stage pipeline that takes one particle per clock while the
// output side keeps up. Each item is the velocity and potential differences of one
// particle, and its path holds four multiplier stages in series (half-kick, then up to
// three rotation products), each followed by a round/saturate/add stage. Every stage
// stalls on its own, so a bubble anywhere lets a new item in even while a finished
// result waits at the output. Mode 0 rotates with the vector cross-product form, mode 1
// with three shears; z is only kicked. The saturated flag reports any clipping along the
// way. Registers are written over the configuration channel, which is always ready;
// indexes five and up are ignored.
module boris_velocity_push (
	input  logic     clk,
	input  logic     arst_n,
	bvp_in_if.sink   vel_in,
	bvp_out_if.source vel_out,
	bvp_cfg_if.sink  cfg
);
	import bvp_pkg::*;

	// Configuration registers
	coef_t kick_x_q, kick_y_q, kick_z_q, rot_t_q, rot_s_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kick_x_q <= '0;
			kick_y_q <= '0;
			kick_z_q <= '0;
			rot_t_q  <= '0;
			rot_s_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_KICK_X: kick_x_q <= cfg.data;
				REG_KICK_Y: kick_y_q <= cfg.data;
				REG_KICK_Z: kick_z_q <= cfg.data;
				REG_ROT_T:  rot_t_q  <= cfg.data;
				REG_ROT_S:  rot_s_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Stage valids and enables; a stage advances when empty or when the next one advances
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en1, en2, en3, en4, en5, en6, en7, en8, en9;

	assign en9 = !v_s9 || vel_out.ready;
	assign en8 = !v_s8 || en9;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign vel_in.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en1) v_s1 <= vel_in.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
			if (en9) v_s9 <= v_s8;
		end
	end

	// Stage 1: half-kick products
	sat_res_t kx_m, ky_m, kz_m;
	logic     mode_s1;
	dp_t      vx_s1, vy_s1, vz_s1;

	bvp_mulq u_kick_x (.clk, .en(en1), .a(dp_t'(vel_in.dphi_x)), .b(kick_x_q), .res(kx_m));
	bvp_mulq u_kick_y (.clk, .en(en1), .a(dp_t'(vel_in.dphi_y)), .b(kick_y_q), .res(ky_m));
	bvp_mulq u_kick_z (.clk, .en(en1), .a(dp_t'(vel_in.dphi_z)), .b(kick_z_q), .res(kz_m));

	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1 <= vel_in.mode;
			vx_s1   <= dp_t'(vel_in.vel_x);
			vy_s1   <= dp_t'(vel_in.vel_y);
			vz_s1   <= dp_t'(vel_in.vel_z);
		end
	end

	// Stage 2: v-minus = v + k
	sat_res_t mx_c, my_c, mz_c;
	logic     mode_s2, flag_s2;
	dp_t      mx_s2, my_s2, mz_s2, kx_s2, ky_s2, kz_s2;

	assign mx_c = sat_sum(vx_s1, kx_m.val, 1'b0);
	assign my_c = sat_sum(vy_s1, ky_m.val, 1'b0);
	assign mz_c = sat_sum(vz_s1, kz_m.val, 1'b0);

	always_ff @(posedge clk) begin
		if (en2) begin
			mode_s2 <= mode_s1;
			mx_s2   <= mx_c.val;
			my_s2   <= my_c.val;
			mz_s2   <= mz_c.val;
			kx_s2   <= kx_m.val;
			ky_s2   <= ky_m.val;
			kz_s2   <= kz_m.val;
			flag_s2 <= kx_m.ovf | ky_m.ovf | kz_m.ovf | mx_c.ovf | my_c.ovf | mz_c.ovf;
		end
	end

	// Stage 3: first rotation products by t
	sat_res_t ty_m, tx_m;
	logic     mode_s3, flag_s3;
	dp_t      mx_s3, my_s3, mz_s3, kx_s3, ky_s3, kz_s3;

	bvp_mulq u_rot_ty (.clk, .en(en3), .a(my_s2), .b(rot_t_q), .res(ty_m));
	bvp_mulq u_rot_tx (.clk, .en(en3), .a(mx_s2), .b(rot_t_q), .res(tx_m));

	always_ff @(posedge clk) begin
		if (en3) begin
			mode_s3 <= mode_s2;
			flag_s3 <= flag_s2;
			mx_s3   <= mx_s2;
			my_s3   <= my_s2;
			mz_s3   <= mz_s2;
			kx_s3   <= kx_s2;
			ky_s3   <= ky_s2;
			kz_s3   <= kz_s2;
		end
	end

	// Stage 4: vp (vector form) or first shear a (shear form, held in the x slot)
	sat_res_t px_c, py_c;
	logic     mode_s4, flag_s4;
	dp_t      px_s4, py_s4, mx_s4, my_s4, mz_s4, kx_s4, ky_s4, kz_s4;

	assign px_c = sat_sum(mx_s3, ty_m.val, 1'b0);
	assign py_c = sat_sum(my_s3, tx_m.val, 1'b1);

	always_ff @(posedge clk) begin
		if (en4) begin
			mode_s4 <= mode_s3;
			flag_s4 <= flag_s3 | ty_m.ovf | px_c.ovf
				| ((mode_s3 == MODE_VECTOR) & (tx_m.ovf | py_c.ovf));
			px_s4   <= px_c.val;
			py_s4   <= py_c.val;
			mx_s4   <= mx_s3;
			my_s4   <= my_s3;
			mz_s4   <= mz_s3;
			kx_s4   <= kx_s3;
			ky_s4   <= ky_s3;
			kz_s4   <= kz_s3;
		end
	end

	// Stage 5: products by s
	sat_res_t sy_m, sx_m;
	logic     mode_s5, flag_s5;
	dp_t      px_s5, mx_s5, my_s5, mz_s5, kx_s5, ky_s5, kz_s5;

	bvp_mulq u_rot_sy (.clk, .en(en5), .a(px_s4), .b(rot_s_q), .res(sy_m));
	bvp_mulq u_rot_sx (.clk, .en(en5), .a(py_s4), .b(rot_s_q), .res(sx_m));

	always_ff @(posedge clk) begin
		if (en5) begin
			mode_s5 <= mode_s4;
			flag_s5 <= flag_s4;
			px_s5   <= px_s4;
			mx_s5   <= mx_s4;
			my_s5   <= my_s4;
			mz_s5   <= mz_s4;
			kx_s5   <= kx_s4;
			ky_s5   <= ky_s4;
			kz_s5   <= kz_s4;
		end
	end

	// Stage 6: ry in both forms; rx for vector form, or carry a for the last shear
	sat_res_t ry_c, rxv_c;
	logic     mode_s6, flag_s6;
	dp_t      rx_s6, ry_s6, mz_s6, kx_s6, ky_s6, kz_s6;

	assign ry_c  = sat_sum(my_s5, sy_m.val, 1'b1);
	assign rxv_c = sat_sum(mx_s5, sx_m.val, 1'b0);

	always_ff @(posedge clk) begin
		if (en6) begin
			mode_s6 <= mode_s5;
			flag_s6 <= flag_s5 | sy_m.ovf | ry_c.ovf
				| ((mode_s5 == MODE_VECTOR) & (sx_m.ovf | rxv_c.ovf));
			rx_s6   <= (mode_s5 == MODE_SHEAR) ? px_s5 : rxv_c.val;
			ry_s6   <= ry_c.val;
			mz_s6   <= mz_s5;
			kx_s6   <= kx_s5;
			ky_s6   <= ky_s5;
			kz_s6   <= kz_s5;
		end
	end

	// Stage 7: last shear product ry * t
	sat_res_t t2_m;
	logic     mode_s7, flag_s7;
	dp_t      rx_s7, ry_s7, mz_s7, kx_s7, ky_s7, kz_s7;

	bvp_mulq u_rot_t2 (.clk, .en(en7), .a(ry_s6), .b(rot_t_q), .res(t2_m));

	always_ff @(posedge clk) begin
		if (en7) begin
			mode_s7 <= mode_s6;
			flag_s7 <= flag_s6;
			rx_s7   <= rx_s6;
			ry_s7   <= ry_s6;
			mz_s7   <= mz_s6;
			kx_s7   <= kx_s6;
			ky_s7   <= ky_s6;
			kz_s7   <= kz_s6;
		end
	end

	// Stage 8: finish shear rx; vector form passes through
	sat_res_t rxs_c;
	logic     flag_s8;
	dp_t      rx_s8, ry_s8, mz_s8, kx_s8, ky_s8, kz_s8;

	assign rxs_c = sat_sum(rx_s7, t2_m.val, 1'b0);

	always_ff @(posedge clk) begin
		if (en8) begin
			flag_s8 <= flag_s7 | ((mode_s7 == MODE_SHEAR) & (t2_m.ovf | rxs_c.ovf));
			rx_s8   <= (mode_s7 == MODE_SHEAR) ? rxs_c.val : rx_s7;
			ry_s8   <= ry_s7;
			mz_s8   <= mz_s7;
			kx_s8   <= kx_s7;
			ky_s8   <= ky_s7;
			kz_s8   <= kz_s7;
		end
	end

	// Stage 9: second half-kick, clip to the result fields; this is the output register
	sat_res_t ox_c, oy_c, oz_c;
	fld_res_t fx_c, fy_c, fz_c;

	assign ox_c = sat_sum(rx_s8, kx_s8, 1'b0);
	assign oy_c = sat_sum(ry_s8, ky_s8, 1'b0);
	assign oz_c = sat_sum(mz_s8, kz_s8, 1'b0);
	assign fx_c = clip_fld(ox_c.val);
	assign fy_c = clip_fld(oy_c.val);
	assign fz_c = clip_fld(oz_c.val);

	always_ff @(posedge clk) begin
		if (en9) begin
			vel_out.new_vx    <= fx_c.val;
			vel_out.new_vy    <= fy_c.val;
			vel_out.new_vz    <= fz_c.val;
			vel_out.saturated <= flag_s8 | ox_c.ovf | oy_c.ovf | oz_c.ovf
				| fx_c.ovf | fy_c.ovf | fz_c.ovf;
		end
	end

	assign vel_out.valid = v_s9;

endmodule
